// ===== hdl/ipv4hx_pkg.sv =====
package ipv4hx_pkg;

  localparam int DEF_MAX_FRAME_BYTES = 16384;

  localparam int ETH_HDR_BYTES   = 14;
  localparam int WORD_BYTES      = 4;
  localparam int UDP_HDR_BYTES   = 8;
  localparam int MIN_IPV4_FRAME  = 34;
  localparam int TCP_MIN_L4      = 13;
  localparam int UDP_MIN_L4      = 6;

  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PASS_TCP          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_UDP          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_MATCH_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_PORT        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_ONLY      = 3'd4;

  typedef enum logic [2:0] {
    ST_TCP      = 3'd0,
    ST_UDP      = 3'd1,
    ST_FILTERED = 3'd2,
    ST_NOT_IPV4 = 3'd3,
    ST_OTHER    = 3'd4,
    ST_TRUNC    = 3'd5
  } status_t;

  typedef struct packed {
    logic [15:0] ether_kind;
    logic [3:0]  ip_header_words;
    logic [15:0] ip_total_length;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [3:0]  tcp_offset_words;
    logic [15:0] udp_total_length;
  } fields_t;

endpackage

// ===== hdl/ipv4hx_in_if.sv =====
interface ipv4hx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       is_last;

  modport source (output valid, output frame_byte, output is_last, input ready);
  modport sink (input valid, input frame_byte, input is_last, output ready);
endinterface

// ===== hdl/ipv4hx_out_if.sv =====
interface ipv4hx_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic [13:0] view_offset;
  logic [15:0] view_length;
  logic        length_underflow;

  modport source (
    output valid, output status, output source_address, output destination_address,
    output source_port, output destination_port, output view_offset,
    output view_length, output length_underflow, input ready
  );
  modport sink (
    input valid, input status, input source_address, input destination_address,
    input source_port, input destination_port, input view_offset,
    input view_length, input length_underflow, output ready
  );
endinterface

// ===== hdl/ipv4hx_cfg_if.sv =====
interface ipv4hx_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ipv4hx_pkg::CFG_IDX_W-1:0]  index;
  logic [ipv4hx_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/ipv4_tcp_udp_header_extractor_unit.sv =====
// Ethernet / IPv4 / TCP / UDP header extractor.
// in_ch carries one frame byte per transfer, with is_last on the final byte.
// out_ch carries one result per frame: status and, zero if rejected, the addresses,
// ports, view (payload offset/length if payload-only, else offset 0, frame length).
// cfg_ch writes the filter and view registers by index and is always ready; the
// user must write it only while no frame is in flight, which the block does not
// enforce. Unknown indexes are ignored. Pipeline: an input register, then the
// field capture and decision logic, then the result register. Throughput is one
// byte per cycle; the only stall point is the result register: a last byte waits
// in the input register while an earlier result is not taken, and the bytes before
// it keep flowing meanwhile.
// Bytes beyond MAX_FRAME_BYTES are dropped; the frame length saturates there.
// Reset (synchronous, rst_n low) empties the pipeline, clears the captured
// fields and loads the register defaults: TCP and UDP pass, no port match,
// whole-frame view.
module ipv4_tcp_udp_header_extractor_unit #(
  parameter int MAX_FRAME_BYTES = ipv4hx_pkg::DEF_MAX_FRAME_BYTES
) (
  input logic         clk,
  input logic         rst_n,
  ipv4hx_in_if.sink   in_ch,
  ipv4hx_out_if.source out_ch,
  ipv4hx_cfg_if.sink  cfg_ch
);

  localparam int PosW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CmpW = (PosW > 8) ? PosW : 8;

  // configuration
  logic        pass_tcp_r;
  logic        pass_udp_r;
  logic        port_match_enable_r;
  logic [15:0] match_port_r;
  logic        payload_only_r;

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       s1_go;
  logic       byte_en;
  logic       load;

  ipv4hx_pkg::fields_t f;
  logic [PosW-1:0]     len;

  // result register
  logic                out_valid_r;
  ipv4hx_pkg::status_t out_status_r;
  logic [31:0]         out_src_addr_r;
  logic [31:0]         out_dst_addr_r;
  logic [15:0]         out_src_port_r;
  logic [15:0]         out_dst_port_r;
  logic [13:0]         out_view_offset_r;
  logic [15:0]         out_view_length_r;
  logic                out_underflow_r;

  ipv4hx_pkg::status_t status_nxt;
  logic [13:0]         view_offset_nxt;
  logic [15:0]         view_length_nxt;
  logic                underflow_nxt;
  logic                is_tcp;
  logic [7:0]          l4;
  logic [7:0]          need;
  logic [7:0]          hdr;
  logic [7:0]          off;
  logic [15:0]         total;
  logic [16:0]         len_ext;
  logic                enabled;
  logic                port_ok;
  logic                accepted;

  // a last byte may only move on when the result register is free
  assign s1_go       = !in_last_r || !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_valid_r || s1_go;
  assign byte_en     = in_valid_r && s1_go;
  assign load        = byte_en && in_last_r;
  assign cfg_ch.ready = 1'b1;

  ipv4hx_capture #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (byte_en),
    .frame_byte(in_byte_r),
    .is_last   (in_last_r),
    .fields    (f),
    .frame_len (len)
  );

  always_comb begin
    is_tcp  = f.ip_protocol == ipv4hx_pkg::PROTO_TCP;
    l4      = 8'(ipv4hx_pkg::ETH_HDR_BYTES) + {2'b00, f.ip_header_words, 2'b00};
    need    = l4 + (is_tcp ? 8'(ipv4hx_pkg::TCP_MIN_L4) : 8'(ipv4hx_pkg::UDP_MIN_L4));
    enabled = is_tcp ? pass_tcp_r : pass_udp_r;
    port_ok = !port_match_enable_r || f.source_port == match_port_r ||
              f.destination_port == match_port_r;

    if (CmpW'(len) < CmpW'(ipv4hx_pkg::ETH_HDR_BYTES)) begin
      status_nxt = ipv4hx_pkg::ST_TRUNC;
    end else if (f.ether_kind != ipv4hx_pkg::ETHERTYPE_IPV4) begin
      status_nxt = ipv4hx_pkg::ST_NOT_IPV4;
    end else if (CmpW'(len) < CmpW'(ipv4hx_pkg::MIN_IPV4_FRAME)) begin
      status_nxt = ipv4hx_pkg::ST_TRUNC;
    end else if (f.ip_protocol != ipv4hx_pkg::PROTO_TCP &&
                 f.ip_protocol != ipv4hx_pkg::PROTO_UDP) begin
      status_nxt = ipv4hx_pkg::ST_OTHER;
    end else if (CmpW'(len) < CmpW'(need)) begin
      status_nxt = ipv4hx_pkg::ST_TRUNC;
    end else if (enabled && port_ok) begin
      status_nxt = is_tcp ? ipv4hx_pkg::ST_TCP : ipv4hx_pkg::ST_UDP;
    end else begin
      status_nxt = ipv4hx_pkg::ST_FILTERED;
    end
    accepted = status_nxt == ipv4hx_pkg::ST_TCP || status_nxt == ipv4hx_pkg::ST_UDP;

    if (is_tcp) begin
      hdr   = {2'b00, f.ip_header_words, 2'b00} + {2'b00, f.tcp_offset_words, 2'b00};
      total = f.ip_total_length;
      off   = 8'(ipv4hx_pkg::ETH_HDR_BYTES) + hdr;
    end else begin
      hdr   = 8'(ipv4hx_pkg::UDP_HDR_BYTES);
      total = f.udp_total_length;
      off   = l4 + 8'(ipv4hx_pkg::UDP_HDR_BYTES);
    end
    len_ext = 17'(len);

    view_offset_nxt = '0;
    view_length_nxt = '0;
    underflow_nxt   = 1'b0;
    if (accepted) begin
      if (payload_only_r) begin
        view_offset_nxt = 14'(off);
        if (total < 16'(hdr)) begin
          underflow_nxt = 1'b1;
        end else begin
          view_length_nxt = total - 16'(hdr);
        end
      end else begin
        view_length_nxt = (len_ext > 17'd65535) ? 16'hFFFF : len_ext[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_tcp_r          <= 1'b1;
      pass_udp_r          <= 1'b1;
      port_match_enable_r <= 1'b0;
      match_port_r        <= '0;
      payload_only_r      <= 1'b0;
      in_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          ipv4hx_pkg::CFG_PASS_TCP:          pass_tcp_r <= cfg_ch.data[0];
          ipv4hx_pkg::CFG_PASS_UDP:          pass_udp_r <= cfg_ch.data[0];
          ipv4hx_pkg::CFG_PORT_MATCH_ENABLE: port_match_enable_r <= cfg_ch.data[0];
          ipv4hx_pkg::CFG_MATCH_PORT:        match_port_r <= cfg_ch.data[15:0];
          ipv4hx_pkg::CFG_PAYLOAD_ONLY:      payload_only_r <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.frame_byte;
      in_last_r <= in_ch.is_last;
    end
    if (load) begin
      out_status_r      <= status_nxt;
      out_src_addr_r    <= accepted ? f.source_address : '0;
      out_dst_addr_r    <= accepted ? f.destination_address : '0;
      out_src_port_r    <= accepted ? f.source_port : '0;
      out_dst_port_r    <= accepted ? f.destination_port : '0;
      out_view_offset_r <= view_offset_nxt;
      out_view_length_r <= view_length_nxt;
      out_underflow_r   <= underflow_nxt;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.status              = out_status_r;
  assign out_ch.source_address      = out_src_addr_r;
  assign out_ch.destination_address = out_dst_addr_r;
  assign out_ch.source_port         = out_src_port_r;
  assign out_ch.destination_port    = out_dst_port_r;
  assign out_ch.view_offset         = out_view_offset_r;
  assign out_ch.view_length         = out_view_length_r;
  assign out_ch.length_underflow    = out_underflow_r;

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ipv4hx_pkg::ST_FILTERED ||
      out_status_r == ipv4hx_pkg::ST_NOT_IPV4 || out_status_r == ipv4hx_pkg::ST_OTHER ||
      out_status_r == ipv4hx_pkg::ST_TRUNC)
    |-> out_src_addr_r == '0 && out_dst_addr_r == '0 && out_src_port_r == '0 &&
        out_dst_port_r == '0 && out_view_offset_r == '0 && out_view_length_r == '0 &&
        !out_underflow_r)
    else $error("rejected frame carries nonzero result fields");

  a_underflow_view: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_underflow_r |-> out_view_length_r == '0 && payload_only_r)
    else $error("underflow without clamped payload view");

  a_frame_view: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !payload_only_r &&
    (out_status_r == ipv4hx_pkg::ST_TCP || out_status_r == ipv4hx_pkg::ST_UDP)
    |-> out_view_offset_r == '0)
    else $error("whole-frame view with nonzero offset");

  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && in_last_r && out_valid_r && !out_ch.ready |-> !in_ch.ready && !load)
    else $error("last byte moved while result register is full");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid_r && in_last_r))
    else $error("result appeared without a last byte");

endmodule

// ===== hdl/ipv4hx_capture.sv =====
module ipv4hx_capture #(
  parameter int MAX_FRAME_BYTES = ipv4hx_pkg::DEF_MAX_FRAME_BYTES,
  localparam int PosW = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_en,
  input  logic [7:0]          frame_byte,
  input  logic                is_last,
  output ipv4hx_pkg::fields_t fields,
  output logic [PosW-1:0]     frame_len
);

  ipv4hx_pkg::fields_t cur_r;
  ipv4hx_pkg::fields_t cur_nxt;
  logic [PosW-1:0]     pos_r;
  logic [PosW-1:0]     pos_nxt;
  logic                in_range;
  logic [3:0]          hw_eff;
  logic [7:0]          l4;
  logic                at_l4;
  logic [PosW-1:0]     rel;

  always_comb begin
    in_range = pos_r < PosW'(MAX_FRAME_BYTES);
    pos_nxt  = in_range ? pos_r + PosW'(1) : pos_r;
    // header length byte takes effect for the transport offset of the same byte
    hw_eff   = (pos_r == PosW'(14)) ? frame_byte[3:0] : cur_r.ip_header_words;
    l4       = 8'(ipv4hx_pkg::ETH_HDR_BYTES) + {2'b00, hw_eff, 2'b00};
    at_l4    = pos_r >= PosW'(l4);
    rel      = pos_r - PosW'(l4);
    cur_nxt  = cur_r;
    if (in_range) begin
      if (pos_r == PosW'(12) || pos_r == PosW'(13)) begin
        cur_nxt.ether_kind = {cur_r.ether_kind[7:0], frame_byte};
      end
      if (pos_r == PosW'(14)) begin
        cur_nxt.ip_header_words = frame_byte[3:0];
      end
      if (pos_r == PosW'(16) || pos_r == PosW'(17)) begin
        cur_nxt.ip_total_length = {cur_r.ip_total_length[7:0], frame_byte};
      end
      if (pos_r == PosW'(23)) begin
        cur_nxt.ip_protocol = frame_byte;
      end
      if (pos_r >= PosW'(26) && pos_r <= PosW'(29)) begin
        cur_nxt.source_address = {cur_r.source_address[23:0], frame_byte};
      end
      if (pos_r >= PosW'(30) && pos_r <= PosW'(33)) begin
        cur_nxt.destination_address = {cur_r.destination_address[23:0], frame_byte};
      end
      if (at_l4) begin
        if (rel == PosW'(0) || rel == PosW'(1)) begin
          cur_nxt.source_port = {cur_r.source_port[7:0], frame_byte};
        end
        if (rel == PosW'(2) || rel == PosW'(3)) begin
          cur_nxt.destination_port = {cur_r.destination_port[7:0], frame_byte};
        end
        if (rel == PosW'(4) || rel == PosW'(5)) begin
          cur_nxt.udp_total_length = {cur_r.udp_total_length[7:0], frame_byte};
        end
        if (rel == PosW'(12)) begin
          cur_nxt.tcp_offset_words = frame_byte[7:4];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      pos_r <= '0;
    end else if (byte_en) begin
      if (is_last) begin
        cur_r <= '0;
        pos_r <= '0;
      end else begin
        cur_r <= cur_nxt;
        pos_r <= pos_nxt;
      end
    end
  end

  assign fields    = cur_nxt;
  assign frame_len = pos_nxt;

endmodule
